>>> rtl/bmt_pkg.sv
// bmt_pkg: item types, result kinds, opcodes and the command decoder
// shared by every module of the bracket matching tokenizer
// no dependencies
package bmt_pkg;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       last;
	} src_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] node_index;
		logic [2:0]  opcode;
		logic [15:0] row;
		logic [15:0] col;
		logic [15:0] partner_index;
		logic        partner_valid;
		logic [16:0] node_count;
		logic [16:0] loop_count;
		logic        last_result;
	} res_item_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stk_ctl_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] op;
	} op_dec_t;

	localparam logic [2:0] KIND_NODE      = 3'd0;
	localparam logic [2:0] KIND_DONE      = 3'd1;
	localparam logic [2:0] KIND_UNMATCHED = 3'd2;
	localparam logic [2:0] KIND_UNCLOSED  = 3'd3;
	localparam logic [2:0] KIND_CAPACITY  = 3'd4;

	localparam logic [2:0] OP_RIGHT = 3'd0;
	localparam logic [2:0] OP_LEFT  = 3'd1;
	localparam logic [2:0] OP_INC   = 3'd2;
	localparam logic [2:0] OP_DEC   = 3'd3;
	localparam logic [2:0] OP_OUT   = 3'd4;
	localparam logic [2:0] OP_IN    = 3'd5;
	localparam logic [2:0] OP_OPEN  = 3'd6;
	localparam logic [2:0] OP_CLOSE = 3'd7;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_RIGHT   = 8'h3E;
	localparam logic [7:0] CH_LEFT    = 8'h3C;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_OPEN    = 8'h5B;
	localparam logic [7:0] CH_CLOSE   = 8'h5D;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	function automatic op_dec_t op_decode(input logic [7:0] b);
		op_dec_t d;
		d.valid = 1'b1;
		case (b)
			CH_RIGHT: d.op = OP_RIGHT;
			CH_LEFT:  d.op = OP_LEFT;
			CH_PLUS:  d.op = OP_INC;
			CH_MINUS: d.op = OP_DEC;
			CH_DOT:   d.op = OP_OUT;
			CH_COMMA: d.op = OP_IN;
			CH_OPEN:  d.op = OP_OPEN;
			CH_CLOSE: d.op = OP_CLOSE;
			default: begin
				d.valid = 1'b0;
				d.op    = OP_RIGHT;
			end
		endcase
		return d;
	endfunction

endpackage

>>> rtl/bmt_stack.sv
// bmt_stack: open bracket stack, top of stack in a register, entries in a memory
// the entry below the top is read ahead so a pop completes without waiting on a memory read
// depends on bmt_pkg
module bmt_stack #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bmt_pkg::stk_ctl_t                 ctl,
	input  logic [15:0]                       push_data,
	output logic [15:0]                       top,
	output logic [$clog2(STACK_DEPTH+1)-1:0] depth
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [15:0]   mem [STACK_DEPTH];
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_next;
	logic [AW-1:0] rd_addr;
	logic [15:0]   top_q;
	logic [15:0]   below_q;

	always_comb begin
		if (ctl.clear) begin
			depth_next = '0;
		end else if (ctl.push) begin
			depth_next = DW'(depth_q + DW'(1));
		end else if (ctl.pop) begin
			depth_next = DW'(depth_q - DW'(1));
		end else begin
			depth_next = depth_q;
		end
		rd_addr = (depth_next >= DW'(2)) ? AW'(depth_next - DW'(2)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_next;
		end
	end

	// slot written on push is never the slot read in the same cycle, but for a push onto an empty stack
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[depth_q[AW-1:0]] <= push_data;
		end
		below_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q <= push_data;
		end else if (ctl.pop) begin
			top_q <= below_q;
		end
	end

	assign top   = top_q;
	assign depth = depth_q;

endmodule

>>> rtl/bmt_core.sv
// bmt_core: position tracking, command decode, counters and result assembly
// for at most one item a cycle, taken when item_valid is set; drives the bracket stack
// depends on bmt_pkg
module bmt_core #(
	parameter int STACK_DEPTH = 256,
	parameter int MAX_NODES   = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  bmt_pkg::src_item_t                item,
	input  logic [15:0]                       stk_top,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] stk_depth,
	output bmt_pkg::stk_ctl_t                 stk_ctl,
	output logic [15:0]                       stk_push_data,
	output logic [1:0]                        res_num,
	output bmt_pkg::res_item_t                res_first,
	output bmt_pkg::res_item_t                res_second
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [16:0] node_q;
	logic [16:0] open_q;
	logic [15:0] last_row_q;
	logic [15:0] last_col_q;
	logic        drain_q;

	bmt_pkg::op_dec_t   dec;
	bmt_pkg::res_item_t byte_res;
	bmt_pkg::res_item_t end_res;
	logic        proc;
	logic        is_nl;
	logic        cmd;
	logic        cap_nodes;
	logic        is_open;
	logic        is_close;
	logic        push_ok;
	logic        pop_ok;
	logic        cap_stack;
	logic        unmatched;
	logic        err;
	logic        node_ok;
	logic        drain_new;
	logic        is_end;
	logic        end_res_ok;
	logic [15:0] col_inc;
	logic [15:0] row_inc;
	logic [16:0] node_new;
	logic [16:0] open_new;
	logic [15:0] last_row_new;
	logic [15:0] last_col_new;
	logic [DW-1:0] depth_new;

	always_comb begin
		proc      = item_valid && item.has_byte && !drain_q;
		is_end    = item_valid && item.last;
		dec       = bmt_pkg::op_decode(item.byte_value);
		is_nl     = item.byte_value == bmt_pkg::CH_NEWLINE;
		col_inc   = (col_q < bmt_pkg::POS_MAX) ? 16'(col_q + 16'd1) : col_q;
		row_inc   = (row_q < bmt_pkg::POS_MAX) ? 16'(row_q + 16'd1) : row_q;
		cmd       = proc && !is_nl && dec.valid;
		cap_nodes = node_q >= 17'(MAX_NODES);
		is_open   = dec.op == bmt_pkg::OP_OPEN;
		is_close  = dec.op == bmt_pkg::OP_CLOSE;
		push_ok   = cmd && !cap_nodes && is_open && (stk_depth < DW'(STACK_DEPTH));
		cap_stack = cmd && !cap_nodes && is_open && (stk_depth >= DW'(STACK_DEPTH));
		unmatched = cmd && !cap_nodes && is_close && (stk_depth == '0);
		pop_ok    = cmd && !cap_nodes && is_close && (stk_depth != '0);
		err       = cmd && (cap_nodes || cap_stack || unmatched);
		node_ok   = cmd && !err;
		drain_new = drain_q || err;

		node_new     = node_ok ? 17'(node_q + 17'd1) : node_q;
		open_new     = push_ok ? 17'(open_q + 17'd1) : open_q;
		last_row_new = node_ok ? row_q : last_row_q;
		last_col_new = node_ok ? col_inc : last_col_q;
		if (push_ok) begin
			depth_new = DW'(stk_depth + DW'(1));
		end else if (pop_ok) begin
			depth_new = DW'(stk_depth - DW'(1));
		end else begin
			depth_new = stk_depth;
		end

		byte_res               = '0;
		byte_res.row           = row_q;
		byte_res.col           = col_inc;
		if (unmatched) begin
			byte_res.kind = bmt_pkg::KIND_UNMATCHED;
		end else if (err) begin
			byte_res.kind = bmt_pkg::KIND_CAPACITY;
		end else begin
			byte_res.kind          = bmt_pkg::KIND_NODE;
			byte_res.node_index    = node_q[15:0];
			byte_res.opcode        = dec.op;
			byte_res.partner_index = pop_ok ? stk_top : 16'd0;
			byte_res.partner_valid = pop_ok;
		end

		end_res_ok = is_end && !drain_new;
		end_res    = '0;
		if (depth_new != '0) begin
			end_res.kind = bmt_pkg::KIND_UNCLOSED;
			end_res.row  = last_row_new;
			end_res.col  = last_col_new;
		end else begin
			end_res.kind       = bmt_pkg::KIND_DONE;
			end_res.node_count = node_new;
			end_res.loop_count = open_new;
		end
		end_res.last_result = 1'b1;

		if (cmd && end_res_ok) begin
			res_num    = 2'd2;
			res_first  = byte_res;
			res_second = end_res;
		end else if (cmd) begin
			res_num                = 2'd1;
			res_first              = byte_res;
			res_first.last_result  = 1'b1;
			res_second             = end_res;
		end else if (end_res_ok) begin
			res_num    = 2'd1;
			res_first  = end_res;
			res_second = end_res;
		end else begin
			res_num    = 2'd0;
			res_first  = byte_res;
			res_second = end_res;
		end

		stk_ctl.push  = push_ok;
		stk_ctl.pop   = pop_ok;
		stk_ctl.clear = is_end;
		stk_push_data = node_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= 16'd1;
			col_q      <= '0;
			node_q     <= '0;
			open_q     <= '0;
			last_row_q <= '0;
			last_col_q <= '0;
			drain_q    <= 1'b0;
		end else if (is_end) begin
			row_q      <= 16'd1;
			col_q      <= '0;
			node_q     <= '0;
			open_q     <= '0;
			last_row_q <= '0;
			last_col_q <= '0;
			drain_q    <= 1'b0;
		end else if (proc) begin
			if (is_nl) begin
				row_q <= row_inc;
				col_q <= '0;
			end else begin
				col_q <= col_inc;
			end
			node_q     <= node_new;
			open_q     <= open_new;
			last_row_q <= last_row_new;
			last_col_q <= last_col_new;
			drain_q    <= drain_new;
		end
	end

endmodule

>>> rtl/bmt_outq.sv
// bmt_outq: four-entry result queue, takes up to two results a cycle
// and hands out one when not stalled; room means at least two entries are free
// depends on bmt_pkg
module bmt_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_num,
	input  bmt_pkg::res_item_t push_first,
	input  bmt_pkg::res_item_t push_second,
	output logic               room,
	output logic               valid,
	input  logic               stall,
	output bmt_pkg::res_item_t data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	bmt_pkg::res_item_t entry_q [DEPTH];
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] wr_ptr_nx;
	logic [CW-1:0] count_q;
	logic          pop;

	assign wr_ptr_nx = PW'(wr_ptr_q + PW'(1));
	assign pop       = (count_q != '0) && !stall;
	assign valid     = count_q != '0;
	assign room      = count_q <= CW'(DEPTH - 2);
	assign data      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_num != 2'd0) begin
			entry_q[wr_ptr_q] <= push_first;
		end
		if (push_num == 2'd2) begin
			entry_q[wr_ptr_nx] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + PW'(1));
			end
			wr_ptr_q <= PW'(wr_ptr_q + PW'(push_num));
			count_q  <= CW'(count_q + CW'(push_num) - CW'(pop));
		end
	end

endmodule

>>> rtl/bracket_matching_tokenizer.sv
// bracket_matching_tokenizer: top level, input register, core, stack and result queue
// depends on bmt_pkg, bmt_stack, bmt_core, bmt_outq
//
// Takes at most one source byte per item and returns node, done or error results.
// An item is taken every cycle while the result queue has room; an item that
// gives a node and an end result together puts both into that four-entry queue,
// which hands them out in turn at the single result port. The bracket stack
// keeps its top in a register and STACK_DEPTH entries in a memory, with the
// entry under the top read ahead, so push and pop each complete without
// waiting on a memory read. The stack memory needs no clearing after reset.
module bracket_matching_tokenizer #(
	parameter int STACK_DEPTH = 256,
	parameter int MAX_NODES   = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  bmt_pkg::src_item_t src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output bmt_pkg::res_item_t res_item
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	bmt_pkg::src_item_t item_s1;
	logic               valid_s1;
	logic               room;
	logic               consume;

	bmt_pkg::stk_ctl_t  stk_ctl;
	logic [15:0]        stk_push_data;
	logic [15:0]        stk_top;
	logic [DW-1:0]      stk_depth;
	logic [1:0]         res_num;
	bmt_pkg::res_item_t res_first;
	bmt_pkg::res_item_t res_second;

	assign consume   = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			item_s1 <= src_item;
		end
	end

	bmt_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_data (stk_push_data),
		.top       (stk_top),
		.depth     (stk_depth)
	);

	bmt_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.MAX_NODES  (MAX_NODES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (consume),
		.item          (item_s1),
		.stk_top       (stk_top),
		.stk_depth     (stk_depth),
		.stk_ctl       (stk_ctl),
		.stk_push_data (stk_push_data),
		.res_num       (res_num),
		.res_first     (res_first),
		.res_second    (res_second)
	);

	bmt_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_num    (res_num),
		.push_first  (res_first),
		.push_second (res_second),
		.room        (room),
		.valid       (res_valid),
		.stall       (res_stall),
		.data        (res_item)
	);

endmodule
